// File: sv/sscol_pkg.sv
// Shared types and constants for the segment-sphere collision test pipeline.
// No dependencies.
`default_nettype none
package sscol_pkg;
  localparam int CW = 32;
  localparam int RW = CW - 1;
  localparam int TB = 32;
  localparam int PW = 2 * CW + 2;
  localparam int NW = PW + 2;

  localparam logic [1:0] REGION_INTERIOR = 2'd0;
  localparam logic [1:0] REGION_START    = 2'd1;
  localparam logic [1:0] REGION_END      = 2'd2;

  localparam logic [4:0] CFG_START_X = 5'd0;
  localparam logic [4:0] CFG_START_Y = 5'd1;
  localparam logic [4:0] CFG_START_Z = 5'd2;
  localparam logic [4:0] CFG_END_X   = 5'd3;
  localparam logic [4:0] CFG_END_Y   = 5'd4;
  localparam logic [4:0] CFG_END_Z   = 5'd5;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic [RW-1:0]        sphere_radius;
  } in_t;

  typedef struct packed {
    logic                 colliding;
    logic signed [CW-1:0] closest_x;
    logic signed [CW-1:0] closest_y;
    logic signed [CW-1:0] closest_z;
    logic [1:0]           region;
    logic                 degenerate;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sz;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [CW-1:0] ez;
  } seg_t;

  typedef struct packed {
    in_t        q;
    logic [1:0] region;
    logic       degen;
  } item_t;

  typedef struct packed {
    logic          v;
    logic [PW-1:0] rem;
    logic [PW-1:0] den;
    logic [TB-1:0] t;
    item_t         item;
  } div_t;
endpackage
`default_nettype wire

// File: sv/segment_sphere_collision_test_core.sv
// Segment-sphere collision test: for each sphere (centre, radius, Q16.16) finds
// the closest point on the configured segment, its region, and whether it lies
// within the radius. Fully pipelined: one query per cycle through 4 front stages
// for dot products, 32 division stages for t, one bit each, and 5 back stages for
// the point and distance compare. A stall on the result side freezes the whole
// pipeline. Write the end points only while idle.
// Depends on sscol_pkg, sscol_front, sscol_div_stage, sscol_back.
`default_nettype none
module segment_sphere_collision_test_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              query_valid,
  output logic                   query_stall,
  input  wire sscol_pkg::in_t    query,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output sscol_pkg::out_t        result,
  input  wire logic              cfg_we,
  input  wire logic [4:0]        cfg_index,
  input  wire logic [sscol_pkg::CW-1:0] cfg_data
);
  localparam int TB = sscol_pkg::TB;

  sscol_pkg::seg_t seg;
  sscol_pkg::div_t dv [TB+1];
  logic ce;

  assign ce = !(result_valid && result_stall);
  assign query_stall = !ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sscol_pkg::CFG_START_X: seg.sx <= cfg_data;
        sscol_pkg::CFG_START_Y: seg.sy <= cfg_data;
        sscol_pkg::CFG_START_Z: seg.sz <= cfg_data;
        sscol_pkg::CFG_END_X:   seg.ex <= cfg_data;
        sscol_pkg::CFG_END_Y:   seg.ey <= cfg_data;
        sscol_pkg::CFG_END_Z:   seg.ez <= cfg_data;
        default: ;
      endcase
    end
  end

  sscol_front u_front (
    .clk(clk), .rst(rst), .ce(ce), .q_valid(query_valid), .q(query),
    .seg(seg), .div(dv[0])
  );

  for (genvar g = 0; g < TB; g++) begin : g_div
    sscol_div_stage u_stage (
      .clk(clk), .rst(rst), .ce(ce), .din(dv[g]), .dout(dv[g+1])
    );
  end

  sscol_back u_back (
    .clk(clk), .rst(rst), .ce(ce), .din(dv[TB]), .seg(seg),
    .res_valid(result_valid), .res(result)
  );

  a_region_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.region != 2'd3)
    else $error("bad region code");

  a_degen_start: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |->
      result.region == sscol_pkg::REGION_START && result.closest_x == seg.sx)
    else $error("degenerate result not at start point");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed under stall");
endmodule
`default_nettype wire

// File: sv/sscol_front.sv
// Front end: direction, dot products, classification into regions.
// Depends on sscol_pkg.
`default_nettype none
module sscol_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            ce,
  input  wire logic            q_valid,
  input  wire sscol_pkg::in_t  q,
  input  wire sscol_pkg::seg_t seg,
  output sscol_pkg::div_t      div
);
  localparam int CW = sscol_pkg::CW;
  localparam int PW = sscol_pkg::PW;
  localparam int NW = sscol_pkg::NW;

  logic signed [CW:0] s_w [3];
  logic signed [CW:0] e_w [3];
  logic signed [CW:0] c_w [3];

  logic                    v1, v2, v3;
  sscol_pkg::in_t          q1, q2, q3;
  logic signed [CW:0]      d1 [3];
  logic signed [CW:0]      cs1 [3];
  logic signed [2*CW+1:0]  prod2 [3];
  logic [2*CW-1:0]         sq2 [3];
  logic signed [NW-1:0]    num3;
  logic [PW-1:0]           den3;

  logic [CW:0]   dneg [3];
  logic [CW-1:0] dmag [3];
  logic [1:0]    region;
  logic          degen;

  always_comb begin
    s_w[0] = {seg.sx[CW-1], seg.sx};
    s_w[1] = {seg.sy[CW-1], seg.sy};
    s_w[2] = {seg.sz[CW-1], seg.sz};
    e_w[0] = {seg.ex[CW-1], seg.ex};
    e_w[1] = {seg.ey[CW-1], seg.ey};
    e_w[2] = {seg.ez[CW-1], seg.ez};
    c_w[0] = {q.center_x[CW-1], q.center_x};
    c_w[1] = {q.center_y[CW-1], q.center_y};
    c_w[2] = {q.center_z[CW-1], q.center_z};
    for (int i = 0; i < 3; i++) begin
      dneg[i] = -d1[i];
      dmag[i] = d1[i][CW] ? dneg[i][CW-1:0] : d1[i][CW-1:0];
    end
  end

  always_comb begin
    degen = (den3 == '0);
    if (degen || num3[NW-1] || num3 == '0) begin
      region = sscol_pkg::REGION_START;
    end else if ($unsigned(num3) >= {{(NW-PW){1'b0}}, den3}) begin
      region = sscol_pkg::REGION_END;
    end else begin
      region = sscol_pkg::REGION_INTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      div.v <= 1'b0;
    end else if (ce) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      div.v <= v3;
    end
    if (ce) begin
      q1 <= q;
      for (int i = 0; i < 3; i++) begin
        d1[i]    <= e_w[i] - s_w[i];
        cs1[i]   <= c_w[i] - s_w[i];
        prod2[i] <= d1[i] * cs1[i];
        sq2[i]   <= dmag[i] * dmag[i];
      end
      q2 <= q1;
      num3 <= NW'(prod2[0]) + NW'(prod2[1]) + NW'(prod2[2]);
      den3 <= PW'(sq2[0]) + PW'(sq2[1]) + PW'(sq2[2]);
      q3 <= q2;
      div.rem <= num3[PW-1:0];
      div.den <= den3;
      div.t <= '0;
      div.item.q <= q3;
      div.item.region <= region;
      div.item.degen <= degen;
    end
  end
endmodule
`default_nettype wire

// File: sv/sscol_div_stage.sv
// One restoring-division step: produces one quotient bit of t.
// Depends on sscol_pkg.
`default_nettype none
module sscol_div_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            ce,
  input  wire sscol_pkg::div_t din,
  output sscol_pkg::div_t      dout
);
  localparam int PW = sscol_pkg::PW;
  localparam int TB = sscol_pkg::TB;

  logic [PW:0] rem2;
  logic [PW:0] diff;
  logic        ge;

  always_comb begin
    rem2 = {din.rem, 1'b0};
    diff = rem2 - {1'b0, din.den};
    ge = (rem2 >= {1'b0, din.den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.v <= 1'b0;
    end else if (ce) begin
      dout.v <= din.v;
    end
    if (ce) begin
      dout.rem  <= ge ? diff[PW-1:0] : rem2[PW-1:0];
      dout.den  <= din.den;
      dout.t    <= {din.t[TB-2:0], ge};
      dout.item <= din.item;
    end
  end
endmodule
`default_nettype wire

// File: sv/sscol_back.sv
// Back end: closest point from t, squared distance and radius compare.
// Depends on sscol_pkg.
`default_nettype none
module sscol_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            ce,
  input  wire sscol_pkg::div_t din,
  input  wire sscol_pkg::seg_t seg,
  output logic                 res_valid,
  output sscol_pkg::out_t      res
);
  localparam int CW = sscol_pkg::CW;
  localparam int RW = sscol_pkg::RW;
  localparam int TB = sscol_pkg::TB;
  localparam int NW = sscol_pkg::NW;

  logic signed [CW-1:0] s_c [3];
  logic signed [CW-1:0] e_c [3];
  logic signed [CW:0]   d_w [3];
  logic [CW:0]          d_n [3];
  logic [CW-1:0]        dmag [3];

  logic                  v1, v2, v3, v4;
  sscol_pkg::item_t      it1, it2, it3, it4;
  logic [CW+TB-1:0]      m1 [3];
  logic signed [CW-1:0]  p2 [3];
  logic signed [CW-1:0]  p3 [3];
  logic signed [CW-1:0]  p4 [3];
  logic [CW-1:0]         a3 [3];
  logic [2*CW-1:0]       sq4 [3];
  logic [2*RW-1:0]       r4;

  logic [CW+TB:0]       mr [3];
  logic [CW-1:0]        off [3];
  logic signed [CW-1:0] pn [3];
  logic signed [CW:0]   df [3];
  logic [CW:0]          dfn [3];
  logic [NW-1:0]        dsq;

  always_comb begin
    s_c[0] = seg.sx; s_c[1] = seg.sy; s_c[2] = seg.sz;
    e_c[0] = seg.ex; e_c[1] = seg.ey; e_c[2] = seg.ez;
    for (int i = 0; i < 3; i++) begin
      d_w[i] = {e_c[i][CW-1], e_c[i]} - {s_c[i][CW-1], s_c[i]};
      d_n[i] = -d_w[i];
      dmag[i] = d_w[i][CW] ? d_n[i][CW-1:0] : d_w[i][CW-1:0];
      mr[i] = {1'b0, m1[i]} + ((CW+TB+1)'(1) << (TB-1));
      off[i] = mr[i][CW+TB-1:TB];
      if (it1.region == sscol_pkg::REGION_INTERIOR) begin
        pn[i] = d_w[i][CW] ? s_c[i] - off[i] : s_c[i] + off[i];
      end else if (it1.region == sscol_pkg::REGION_END) begin
        pn[i] = e_c[i];
      end else begin
        pn[i] = s_c[i];
      end
    end
    df[0] = {it2.q.center_x[CW-1], it2.q.center_x} - {p2[0][CW-1], p2[0]};
    df[1] = {it2.q.center_y[CW-1], it2.q.center_y} - {p2[1][CW-1], p2[1]};
    df[2] = {it2.q.center_z[CW-1], it2.q.center_z} - {p2[2][CW-1], p2[2]};
    for (int i = 0; i < 3; i++) begin
      dfn[i] = -df[i];
    end
    dsq = NW'(sq4[0]) + NW'(sq4[1]) + NW'(sq4[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      res_valid <= 1'b0;
    end else if (ce) begin
      v1 <= din.v;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      res_valid <= v4;
    end
    if (ce) begin
      it1 <= din.item;
      it2 <= it1;
      it3 <= it2;
      it4 <= it3;
      for (int i = 0; i < 3; i++) begin
        m1[i]  <= dmag[i] * din.t;
        p2[i]  <= pn[i];
        p3[i]  <= p2[i];
        p4[i]  <= p3[i];
        a3[i]  <= df[i][CW] ? dfn[i][CW-1:0] : df[i][CW-1:0];
        sq4[i] <= a3[i] * a3[i];
      end
      r4 <= it3.q.sphere_radius * it3.q.sphere_radius;
      res.colliding  <= ({{(NW-2*RW){1'b0}}, r4} >= dsq);
      res.closest_x  <= p4[0];
      res.closest_y  <= p4[1];
      res.closest_z  <= p4[2];
      res.region     <= it4.region;
      res.degenerate <= it4.degen;
    end
  end
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Testbench for segment_sphere_collision_test_core: random and directed sphere
// queries against several segments, checked beat by beat against a local model.
// Depends on sscol_pkg and the core RTL.
`timescale 1ns / 100ps
module testbench;
  localparam int CW = sscol_pkg::CW;
  localparam int RW = sscol_pkg::RW;
  localparam int TB = sscol_pkg::TB;

  class hit_scoreboard;
    sscol_pkg::out_t pending[$];
    int errors;

    task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void note_query(sscol_pkg::out_t exp);
      pending.push_back(exp);
    endfunction

    task automatic check_result(sscol_pkg::out_t got);
      sscol_pkg::out_t exp;
      if (pending.size() == 0) begin
        report("result beat with nothing pending");
        return;
      end
      exp = pending.pop_front();
      if (got.colliding !== exp.colliding)
        report($sformatf("colliding %0b exp %0b", got.colliding, exp.colliding));
      if (got.closest_x !== exp.closest_x)
        report($sformatf("closest_x %0d exp %0d", got.closest_x, exp.closest_x));
      if (got.closest_y !== exp.closest_y)
        report($sformatf("closest_y %0d exp %0d", got.closest_y, exp.closest_y));
      if (got.closest_z !== exp.closest_z)
        report($sformatf("closest_z %0d exp %0d", got.closest_z, exp.closest_z));
      if (got.region !== exp.region)
        report($sformatf("region %0d exp %0d", got.region, exp.region));
      if (got.degenerate !== exp.degenerate)
        report($sformatf("degenerate %0b exp %0b", got.degenerate, exp.degenerate));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic query_valid = 0;
  logic query_stall;
  sscol_pkg::in_t query = '0;
  logic result_valid;
  logic result_stall = 0;
  sscol_pkg::out_t result;
  logic cfg_we = 0;
  logic [4:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  hit_scoreboard sb;
  logic signed [CW-1:0] seg_s[3];
  logic signed [CW-1:0] seg_e[3];
  int cycles;
  bit hold_off;
  bit recv_idle;

  segment_sphere_collision_test_core DUT (
    .clk(clk), .rst(rst),
    .query_valid(query_valid), .query_stall(query_stall), .query(query),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic sscol_pkg::out_t closest_point(sscol_pkg::in_t q);
    sscol_pkg::out_t r;
    logic signed [CW:0] d[3];
    logic signed [CW:0] cs[3];
    logic signed [CW:0] diff;
    logic signed [CW-1:0] p[3];
    logic signed [127:0] num;
    logic [127:0] den, dsq, r2, rem, m;
    logic [TB-1:0] t;
    logic [CW:0] mg;
    logic signed [CW-1:0] c[3];
    c[0] = q.center_x; c[1] = q.center_y; c[2] = q.center_z;
    num = 0; den = 0; dsq = 0;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({seg_e[i][CW-1], seg_e[i]}) - $signed({seg_s[i][CW-1], seg_s[i]});
      cs[i] = $signed({c[i][CW-1], c[i]}) - $signed({seg_s[i][CW-1], seg_s[i]});
      num += 128'(d[i]) * 128'(cs[i]);
      den += 128'(d[i] * 128'(d[i]));
    end
    if (den == 0) begin
      r.degenerate = 1;
      r.region = sscol_pkg::REGION_START;
      for (int i = 0; i < 3; i++) p[i] = seg_s[i];
    end else if (num <= 0) begin
      r.region = sscol_pkg::REGION_START;
      for (int i = 0; i < 3; i++) p[i] = seg_s[i];
    end else if ($unsigned(num) >= den) begin
      r.region = sscol_pkg::REGION_END;
      for (int i = 0; i < 3; i++) p[i] = seg_e[i];
    end else begin
      r.region = sscol_pkg::REGION_INTERIOR;
      rem = $unsigned(num) << TB;
      t = TB'(rem / den);
      for (int i = 0; i < 3; i++) begin
        mg = d[i] < 0 ? -d[i] : d[i];
        m = (128'(mg) * 128'(t) + (128'(1) << (TB - 1))) >> TB;
        p[i] = d[i] < 0 ? seg_s[i] - CW'(m) : seg_s[i] + CW'(m);
      end
    end
    for (int i = 0; i < 3; i++) begin
      diff = $signed({c[i][CW-1], c[i]}) - $signed({p[i][CW-1], p[i]});
      mg = diff < 0 ? -diff : diff;
      dsq += 128'(mg) * 128'(mg);
    end
    r2 = 128'(q.sphere_radius) * 128'(q.sphere_radius);
    r.colliding = r2 >= dsq;
    r.closest_x = p[0]; r.closest_y = p[1]; r.closest_z = p[2];
    return r;
  endfunction

  task automatic write_reg(logic [4:0] idx, logic [CW-1:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      sscol_pkg::CFG_START_X: seg_s[0] = val;
      sscol_pkg::CFG_START_Y: seg_s[1] = val;
      sscol_pkg::CFG_START_Z: seg_s[2] = val;
      sscol_pkg::CFG_END_X:   seg_e[0] = val;
      sscol_pkg::CFG_END_Y:   seg_e[1] = val;
      sscol_pkg::CFG_END_Z:   seg_e[2] = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_segment(logic [CW-1:0] sx, sy, sz, ex, ey, ez);
    write_reg(sscol_pkg::CFG_START_X, sx); write_reg(sscol_pkg::CFG_START_Y, sy);
    write_reg(sscol_pkg::CFG_START_Z, sz); write_reg(sscol_pkg::CFG_END_X, ex);
    write_reg(sscol_pkg::CFG_END_Y, ey); write_reg(sscol_pkg::CFG_END_Z, ez);
  endtask

  task automatic send_query(sscol_pkg::in_t q, bit no_gap);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0);
    if (gap > 0) begin
      query_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    query_valid <= 1;
    query <= q;
    do @(posedge clk); while (query_stall);
    sb.note_query(closest_point(q));
  endtask

  task automatic drain();
    query_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return CW'($signed($urandom_range(0, 2 * 65536 * 20)) - 65536 * 20);
      default: return CW'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic sscol_pkg::in_t rand_query(int mode);
    sscol_pkg::in_t q;
    q.center_x = rand_coord(mode);
    q.center_y = rand_coord(mode);
    q.center_z = rand_coord(mode);
    case ($urandom_range(0, 3))
      0: q.sphere_radius = RW'($urandom());
      1: q.sphere_radius = RW'($urandom_range(0, 65536 * 30));
      2: q.sphere_radius = RW'($urandom_range(0, 300));
      default: q.sphere_radius = 0;
    endcase
    return q;
  endfunction

  // receiver: random stalls, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 0;
    end else begin
      if (result_valid && !result_stall) sb.check_result(result);
      result_stall <= hold_off || recv_idle;
    end
  end

  initial begin
    int n;
    recv_idle = 0;
    forever begin
      @(posedge clk);
      if (!rst && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(0, 18);
        recv_idle = 1;
        repeat (n) @(posedge clk);
        recv_idle = 0;
        repeat ($urandom_range(0, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  localparam logic [CW-1:0] MAXC = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] MINC = 32'h8000_0000;

  initial begin
    sscol_pkg::in_t q;
    int mode;
    sb = new();
    cycles = 0;
    hold_off = 0;
    for (int i = 0; i < 3; i++) begin
      seg_s[i] = 0; seg_e[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset segment is degenerate
    q = '0; q.sphere_radius = 5; send_query(q, 0);
    drain();
    set_segment(0, 0, 0, 32'h000A_0000, 0, 0);
    q = '0; q.center_x = 32'h0005_0000; q.center_y = 32'h0001_0000;
    q.sphere_radius = RW'(32'h0001_0000); send_query(q, 0);
    q.center_y = 32'h0001_0001; send_query(q, 0);
    q.center_x = 32'hFFFF_0000; send_query(q, 0);
    q.center_x = 32'h000B_0000; send_query(q, 0);
    q.center_x = 0; q.center_y = 0; send_query(q, 0);
    q.center_x = 32'h000A_0000; send_query(q, 0);
    q = '0; q.center_x = MAXC; q.center_y = MINC; q.center_z = MAXC;
    q.sphere_radius = '1; send_query(q, 0);
    q.center_x = MINC; q.center_y = MAXC; q.center_z = MINC; send_query(q, 0);
    drain();
    set_segment(MINC, MINC, MINC, MAXC, MAXC, MAXC);
    q = '0; q.sphere_radius = '1; send_query(q, 0);
    q.center_x = MAXC; q.center_y = MINC; q.center_z = 1; send_query(q, 0);
    q.center_x = 12345; q.center_y = -7; q.center_z = 99; q.sphere_radius = 0;
    send_query(q, 0);
    drain();
    set_segment(MAXC, 0, MINC, MINC, 1, MAXC);
    for (int i = 0; i < 6; i++) send_query(rand_query(0), 0);
    drain();
    // out-of-range index is ignored
    write_reg(5'd6, 32'h1234_5678);
    write_reg(5'd31, 32'hFFFF_FFFF);
    set_segment(7, 7, 7, 7, 7, 7);
    send_query(rand_query(2), 0);
    q = '0; q.center_x = 7; q.center_y = 7; q.center_z = 7; send_query(q, 0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      mode = $urandom_range(0, 2);
      set_segment(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                  rand_coord(mode), rand_coord(mode), rand_coord(mode));
      if (ph == 3) begin
        fork
          begin
            hold_off = 1;
            repeat (150) @(posedge clk);
            hold_off = 0;
          end
          for (int i = 0; i < 60; i++) send_query(rand_query($urandom_range(0, 2)), 1);
        join
      end else begin
        for (int i = 0; i < 45; i++) send_query(rand_query($urandom_range(0, 2)), 0);
      end
      drain();
    end

    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
